FILE: design/ms_pkg.sv
// Shared types and constants for the merge sorter.
`timescale 1ns / 1ps

package ms_pkg;

    localparam int DATA_W = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_RD_I,
        ST_RD_J,
        ST_PICK,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } t_state;

    // Request from the sequencer to the output register
    typedef struct packed {
        logic load;
        logic last;
        logic ovf;
    } t_emit;

endpackage

FILE: design/merge_sorter_unit.sv
// Merge sorter top level: two ping-pong buffers, sequencer and output register.
// Values load one per cycle into buffer 0 until a request with i_last set; up
// to MAX_ITEMS values are kept and later ones are dropped and flag overflow.
// The set of n values is then sorted by bottom-up merge passes that alternate
// between the two single-port-read buffers: ceil(log2 n) passes, in which each
// element goes through read left head, read right head, and compare and write,
// and each merged run pair has a setup step first. Each sorted value is read and
// then loaded into the output register, waiting while that register is held full;
// the input is stalled from the final value of a set until its last result is in
// the output register.
`timescale 1ns / 1ps

module merge_sorter_unit import ms_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_value_res,
    output logic                     o_last_res,
    output logic                     o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);

    logic                     w_we0;
    logic                     w_we1;
    logic [AW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wdata;
    logic [AW-1:0]            w_raddr;
    logic signed [DATA_W-1:0] w_rdata0;
    logic signed [DATA_W-1:0] w_rdata1;
    logic                     w_out_free;
    t_emit                    w_emit;
    logic signed [DATA_W-1:0] w_emit_value;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;

    assign w_out_free = !r_out_valid || !i_stall;

    ms_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_last       (i_last),
        .i_out_free   (w_out_free),
        .o_we0        (w_we0),
        .o_we1        (w_we1),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata),
        .o_raddr      (w_raddr),
        .i_rdata0     (w_rdata0),
        .i_rdata1     (w_rdata1),
        .o_emit       (w_emit),
        .o_emit_value (w_emit_value)
    );

    // Buffer 0 holds the loaded set; the buffers swap roles each pass
    ms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata0)
    );

    ms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_buf1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata1)
    );

    // Output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_out_value <= w_emit_value;
            r_out_last  <= w_emit.last;
            r_out_ovf   <= w_emit.ovf;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_last_res  = r_out_last;
    assign o_overflow  = r_out_ovf;

    // A new result only enters an empty output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit.load |-> !r_out_valid)
        else $error("result loaded over a pending result");

    // Only one buffer is written in a cycle
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we0 && w_we1))
        else $error("both buffers written at once");

    // Merge writes into buffer 1 never overlap loading
    a_merge_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we1 |-> o_stall)
        else $error("merge write while input open");

endmodule

FILE: design/ms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ms_ctrl.sv
// Load, merge-pass and emit sequencer for the merge sorter.
`timescale 1ns / 1ps

module ms_ctrl import ms_pkg::*; #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_W-1:0]     i_value,
    input  logic                         i_last,
    input  logic                         i_out_free,
    output logic                         o_we0,
    output logic                         o_we1,
    output logic [$clog2(MAX_ITEMS)-1:0] o_waddr,
    output logic signed [DATA_W-1:0]     o_wdata,
    output logic [$clog2(MAX_ITEMS)-1:0] o_raddr,
    input  logic signed [DATA_W-1:0]     i_rdata0,
    input  logic signed [DATA_W-1:0]     i_rdata1,
    output t_emit                        o_emit,
    output logic signed [DATA_W-1:0]     o_emit_value
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_src, n_src;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_emit_idx, n_emit_idx;
    logic signed [DATA_W-1:0] r_head, n_head;

    logic                     w_accept;
    logic                     w_room;
    logic [CW-1:0]            w_load_count;
    logic signed [DATA_W-1:0] w_rd;
    logic [SW-1:0]            w_n_ext;
    logic [SW-1:0]            w_lo_w;
    logic [SW-1:0]            w_width2;
    logic [SW-1:0]            w_lo_2w;
    logic [SW-1:0]            w_mid_full;
    logic [SW-1:0]            w_hi_full;
    logic                     w_take_left;
    logic                     w_merge_done;
    logic                     w_pass_done;
    logic                     w_sort_done;
    logic                     w_emit_last;

    // Shared decode of the current step
    assign w_accept     = i_valid && (r_state == ST_LOAD);
    assign w_room       = r_count < MAX_CNT;
    assign w_load_count = w_room ? r_count + 1'b1 : r_count;
    assign w_rd         = r_src ? i_rdata1 : i_rdata0;
    assign w_n_ext      = {1'b0, r_count};
    assign w_lo_w       = {1'b0, r_lo} + {1'b0, r_width};
    assign w_width2     = {r_width, 1'b0};
    assign w_lo_2w      = {1'b0, r_lo} + w_width2;
    assign w_mid_full   = (w_lo_w > w_n_ext) ? w_n_ext : w_lo_w;
    assign w_hi_full    = (w_lo_2w > w_n_ext) ? w_n_ext : w_lo_2w;
    assign w_take_left  = (r_i < r_mid) && ((r_j >= r_hi) || (r_head <= w_rd));
    assign w_merge_done = (r_k + 1'b1) == r_hi;
    assign w_pass_done  = w_lo_2w >= w_n_ext;
    assign w_sort_done  = w_width2 >= w_n_ext;
    assign w_emit_last  = (r_emit_idx + 1'b1) == r_count;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = (w_load_count > CW'(1)) ? ST_PASS : ST_EMIT_RD;
                end
            end
            ST_PASS: n_state = ST_RD_I;
            ST_RD_I: n_state = ST_RD_J;
            ST_RD_J: n_state = ST_PICK;
            ST_PICK: begin
                if (!w_merge_done) begin
                    n_state = ST_RD_I;
                end else if (w_pass_done && w_sort_done) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_PASS;
                end
            end
            ST_EMIT_RD: begin
                if (i_out_free) begin
                    n_state = ST_EMIT_CAP;
                end
            end
            ST_EMIT_CAP: n_state = w_emit_last ? ST_LOAD : ST_EMIT_RD;
            default: n_state = ST_LOAD;
        endcase
    end

    // Outputs: memory ports and emit request
    always_comb begin
        o_stall      = (r_state != ST_LOAD);
        o_we0        = 1'b0;
        o_we1        = 1'b0;
        o_waddr      = r_k[AW-1:0];
        o_wdata      = w_take_left ? r_head : w_rd;
        o_raddr      = r_i[AW-1:0];
        o_emit       = '0;
        o_emit_value = w_rd;
        unique case (r_state)
            ST_LOAD: begin
                o_we0   = w_accept && w_room;
                o_waddr = r_count[AW-1:0];
                o_wdata = i_value;
            end
            ST_RD_J: begin
                o_raddr = r_j[AW-1:0];
            end
            ST_PICK: begin
                o_we0 = r_src;
                o_we1 = !r_src;
            end
            ST_EMIT_RD: begin
                o_raddr = r_emit_idx[AW-1:0];
            end
            ST_EMIT_CAP: begin
                o_emit.load = 1'b1;
                o_emit.last = w_emit_last;
                o_emit.ovf  = r_ovf;
            end
            default: begin
            end
        endcase
    end

    // Counters, run bounds and head register
    always_comb begin
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_src      = r_src;
        n_width    = r_width;
        n_lo       = r_lo;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_emit_idx = r_emit_idx;
        n_head     = r_head;
        case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    n_count = w_load_count;
                    if (!w_room) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_width    = CW'(1);
                        n_lo       = '0;
                        n_src      = 1'b0;
                        n_emit_idx = '0;
                    end
                end
            end
            ST_PASS: begin
                n_mid = w_mid_full[CW-1:0];
                n_hi  = w_hi_full[CW-1:0];
                n_i   = r_lo;
                n_j   = w_mid_full[CW-1:0];
                n_k   = r_lo;
            end
            ST_RD_J: begin
                n_head = w_rd;
            end
            ST_PICK: begin
                if (w_take_left) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (w_merge_done) begin
                    if (w_pass_done) begin
                        // Swap buffers and double the run width
                        n_src      = !r_src;
                        n_width    = w_width2[CW-1:0];
                        n_lo       = '0;
                        n_emit_idx = '0;
                    end else begin
                        n_lo = w_lo_2w[CW-1:0];
                    end
                end
            end
            ST_EMIT_CAP: begin
                if (w_emit_last) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_emit_idx = r_emit_idx + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_src      <= 1'b0;
            r_width    <= '0;
            r_lo       <= '0;
            r_mid      <= '0;
            r_hi       <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_emit_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_src      <= n_src;
            r_width    <= n_width;
            r_lo       <= n_lo;
            r_mid      <= n_mid;
            r_hi       <= n_hi;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_emit_idx <= n_emit_idx;
        end
    end

    // Hold the left-run head between reads
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end

endmodule

FILE: tb/merge_sorter_unit_test.sv
// Self-checking testbench for the merge sorter: directed and random sets with a sorting predictor.
`timescale 1ns / 1ps

module merge_sorter_unit_test;
    import ms_pkg::*;

    localparam int SET_CAP      = 64;
    localparam int STUCK_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_res;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     i_last  = 1'b0;
    logic                     i_stall = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_value_res;
    logic                     o_last_res;
    logic                     o_overflow;

    // Predictor state: values of the open set and the sorted results still owed
    logic signed [DATA_W-1:0] set_vals [$];
    logic                     set_over = 1'b0;
    t_sorted_res              sorted_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    int values_in     = 0;
    int sets_closed   = 0;
    int sets_overflow = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int stuck_cycles  = 0;

    merge_sorter_unit #(.MAX_ITEMS(SET_CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sort the closed set (stable insertion sort) and queue its results
    task automatic queue_sorted_run();
        logic signed [DATA_W-1:0] key;
        t_sorted_res              res;
        int                       j;
        for (int i = 1; i < set_vals.size(); i++) begin
            key = set_vals[i];
            j = i - 1;
            while (j >= 0 && set_vals[j] > key) begin
                set_vals[j + 1] = set_vals[j];
                j--;
            end
            set_vals[j + 1] = key;
        end
        for (int k = 0; k < set_vals.size(); k++) begin
            res.value = set_vals[k];
            res.last  = (k == set_vals.size() - 1);
            res.ovf   = set_over;
            sorted_q.push_back(res);
        end
        set_vals.delete();
        set_over = 1'b0;
    endtask

    // Track accepted input requests and predict the sorted output
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            values_in++;
            if (set_vals.size() < SET_CAP) begin
                set_vals.push_back(i_value);
            end else begin
                set_over = 1'b1;
            end
            if (i_last) begin
                sets_closed++;
                if (set_over) begin
                    sets_overflow++;
                end
                queue_sorted_run();
            end
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_sorted_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result value=%0d last=%0b ovf=%0b",
                             $realtime, o_value_res, o_last_res, o_overflow);
                end
            end else begin
                exp_res = sorted_q.pop_front();
                if (o_value_res !== exp_res.value || o_last_res !== exp_res.last ||
                    o_overflow !== exp_res.ovf) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: mismatch exp value=%0d last=%0b ovf=%0b",
                                 $realtime, exp_res.value, exp_res.last, exp_res.ovf);
                        $display("%0t:          got value=%0d last=%0b ovf=%0b",
                                 $realtime, o_value_res, o_last_res, o_overflow);
                    end
                end
            end
        end
    end

    // Drive the result stall: long hold-off on request, else random
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Abort when nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no request moved for %0d cycles", STUCK_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            return $urandom;
        end
        if (pick < 8) begin
            // narrow range to get plenty of repeats
            return $urandom_range(0, 15) - 8;
        end
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    // Offer one request, with random idle cycles first, and wait until taken
    task automatic send_req(input logic signed [DATA_W-1:0] value, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random_set(input int count);
        for (int i = 0; i < count; i++) begin
            send_req(rand_value(), i == count - 1);
        end
    endtask

    // Stop offering and wait until every owed result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_single_values();
        send_req(32'sh8000_0000, 1'b1);
        send_req(32'sh7fff_ffff, 1'b1);
        wait_drained();
    endtask

    task automatic test_extreme_values();
        send_req(32'sh7fff_ffff, 1'b0);
        send_req(32'sh8000_0000, 1'b0);
        send_req(32'sd0, 1'b0);
        send_req(-32'sd1, 1'b0);
        send_req(32'sd1, 1'b1);
        wait_drained();
    endtask

    task automatic test_repeated_values();
        send_req(32'sd5, 1'b0);
        send_req(-32'sd3, 1'b0);
        send_req(32'sd5, 1'b0);
        send_req(32'sd5, 1'b0);
        send_req(-32'sd3, 1'b0);
        send_req(32'sd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_ordered_sets();
        // already ascending, then descending, then a swapped pair
        for (int i = 1; i <= 4; i++) begin
            send_req(i, i == 4);
        end
        for (int i = 3; i >= 1; i--) begin
            send_req(i, i == 1);
        end
        send_req(32'sd1, 1'b0);
        send_req(32'sd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_sets(input int item_goal);
        int sent;
        int count;
        sent = 0;
        while (sent < item_goal) begin
            count = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            send_random_set(count);
            sent += count;
        end
        wait_drained();
    endtask

    task automatic test_full_set();
        send_random_set(SET_CAP);
        wait_drained();
    endtask

    task automatic test_overflow_set();
        // extra values past capacity, the closing one among them, are dropped
        send_random_set(SET_CAP + $urandom_range(1, 3));
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        send_random_set(8);
        send_random_set(5);
        send_random_set(3);
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 34;
        recv_stall_pct = 70;
        test_single_values();
        test_extreme_values();
        test_repeated_values();
        test_ordered_sets();
        test_random_sets(5);
        test_full_set();

        send_idle_pct  = 70;
        recv_stall_pct = 34;
        test_random_sets(5);
        test_overflow_set();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_sets(5);
        test_output_hold_off();

        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Sorted %0d sets from %0d values (%0d over capacity), %0d results checked,",
                 sets_closed, values_in, sets_overflow, results_seen);
        $display("across three idle mixes and a long output hold-off; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && sorted_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
